[design/opc_pkg.sv]
// Shared constants, types and helpers for the one-vs-rest linear classifier.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package opc_pkg;

  localparam int PIXEL_COUNT = 784;
  localparam int CLASS_COUNT = 10;
  localparam int WEIGHT_BITS = 16;

  localparam int ACT_W   = 1;
  localparam int CLASS_W = 4;
  localparam int WIDX_W  = 10;
  localparam int WVAL_W  = 16;
  localparam int PIX_W   = 8;

  localparam int PROD_W  = WEIGHT_BITS + PIX_W;
  localparam int SCORE_W = PROD_W + $clog2(PIXEL_COUNT + 1) + 1;
  localparam int POS_W   = $clog2(PIXEL_COUNT + 1);
  localparam int ADDR_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_WEIGHT = 1'b0,
    ACT_PIXEL  = 1'b1
  } action_e;

  typedef struct packed {
    logic                             valid;
    action_e                          action;
    logic [CLASS_W-1:0]               class_index;
    logic [WIDX_W-1:0]                weight_index;
    logic signed [WVAL_W-1:0]         weight_value;
    logic [PIX_W-1:0]                 pixel_value;
    logic                             last_pixel;
    logic [CLASS_W-1:0]               true_label;
    logic signed [SCORE_W-1:0]        best_score;
    logic [CLASS_W-1:0]               best_class;
  } opc_tok_t;

  typedef struct packed {
    logic [CLASS_W-1:0] predicted_class;
    logic               is_mismatch;
  } opc_res_t;

  // wrap the 16-bit input weight into WEIGHT_BITS two's complement
  function automatic logic signed [WEIGHT_BITS-1:0] to_weight(
    input logic signed [WVAL_W-1:0] raw
  );
    logic signed [31:0] ext;
    ext = {{(32 - WVAL_W){raw[WVAL_W-1]}}, raw};
    return ext[WEIGHT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[design/opc_if.sv]
// Valid/ready channel interfaces for the classifier: input items and results.
// Depends on opc_pkg for field widths.
`default_nettype none

interface opc_in_if;
  import opc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [CLASS_W-1:0]       class_index;
  logic [WIDX_W-1:0]        weight_index;
  logic signed [WVAL_W-1:0] weight_value;
  logic [PIX_W-1:0]         pixel_value;
  logic                     last_pixel;
  logic [CLASS_W-1:0]       true_label;

  modport source (
    output valid, action, class_index, weight_index, weight_value,
           pixel_value, last_pixel, true_label,
    input  ready
  );
  modport sink (
    input  valid, action, class_index, weight_index, weight_value,
           pixel_value, last_pixel, true_label,
    output ready
  );
endinterface

interface opc_out_if;
  import opc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] predicted_class;
  logic               is_mismatch;

  modport source (output valid, predicted_class, is_mismatch, input ready);
  modport sink (input valid, predicted_class, is_mismatch, output ready);
endinterface

`default_nettype wire

[design/opc_cell.sv]
// One class cell: weight row memory, bias, running score and argmax step.
// Depends on opc_pkg; tokens enter from the left neighbour, leave to the right.
`default_nettype none

module opc_cell (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    adv_i,
  input  wire [opc_pkg::CLASS_W-1:0] cell_id_i,
  input  opc_pkg::opc_tok_t      tok_i,
  output opc_pkg::opc_tok_t      tok_o
);
  import opc_pkg::*;

  logic signed [WEIGHT_BITS-1:0] wmem_q [PIXEL_COUNT];
  logic signed [PROD_W-1:0]      bias255_q;
  logic signed [WEIGHT_BITS-1:0] rdata_q;
  logic signed [PROD_W-1:0]      prod_q, prod_d;
  logic signed [SCORE_W-1:0]     final_q, final_d;
  logic signed [SCORE_W-1:0]     acc_q, acc_d, sum;
  logic [POS_W-1:0]              pos_q, pos_d;
  opc_tok_t                      a_q, b_q, c_q, d_q, d_d;
  logic                          add_a_q, add_b_q, add_a_d;
  logic                          wr_a, wr_bias, pix_a, pix_b, last_b, take;
  logic signed [WEIGHT_BITS-1:0] wval, bval;

  always_comb begin
    wval    = to_weight(tok_i.weight_value);
    wr_a    = tok_i.valid && tok_i.action == ACT_WEIGHT
              && tok_i.class_index == cell_id_i
              && 32'(tok_i.weight_index) < PIXEL_COUNT;
    pix_a   = tok_i.valid && tok_i.action == ACT_PIXEL;
    add_a_d = pix_a && pos_q < POS_W'(PIXEL_COUNT);
    pos_d   = pos_q;
    if (pix_a) begin
      if (tok_i.last_pixel) begin
        pos_d = '0;
      end else if (add_a_d) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_comb begin
    prod_d = $signed({1'b0, a_q.pixel_value}) * rdata_q;
  end

  always_comb begin
    bval    = to_weight(b_q.weight_value);
    wr_bias = b_q.valid && b_q.action == ACT_WEIGHT
              && b_q.class_index == cell_id_i
              && 32'(b_q.weight_index) == PIXEL_COUNT;
    pix_b   = b_q.valid && b_q.action == ACT_PIXEL;
    last_b  = pix_b && b_q.last_pixel;
    sum     = acc_q + (add_b_q ? SCORE_W'(prod_q) : '0);
    final_d = sum + SCORE_W'(bias255_q);
    acc_d   = acc_q;
    if (pix_b) begin
      acc_d = last_b ? '0 : sum;
    end
  end

  always_comb begin
    take = (cell_id_i == '0) || (final_q > c_q.best_score);
    d_d  = c_q;
    if (c_q.valid && c_q.action == ACT_PIXEL && c_q.last_pixel && take) begin
      d_d.best_score = final_q;
      d_d.best_class = cell_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q     <= '0;
      b_q     <= '0;
      c_q     <= '0;
      d_q     <= '0;
      add_a_q <= 1'b0;
      add_b_q <= 1'b0;
      pos_q   <= '0;
      acc_q   <= '0;
    end else if (adv_i) begin
      a_q     <= tok_i;
      b_q     <= a_q;
      c_q     <= b_q;
      d_q     <= d_d;
      add_a_q <= add_a_d;
      add_b_q <= add_a_q;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (wr_a) begin
        wmem_q[ADDR_W'(tok_i.weight_index)] <= wval;
      end
      if (add_a_d) begin
        rdata_q <= wmem_q[pos_q[ADDR_W-1:0]];
      end
      if (wr_bias) begin
        bias255_q <= (PROD_W'(bval) <<< PIX_W) - PROD_W'(bval);
      end
      prod_q  <= prod_d;
      final_q <= final_d;
    end
  end

  assign tok_o = d_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(PIXEL_COUNT))
    else $error("pixel position beyond image size");

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && last_b) |=> acc_q == '0)
    else $error("score not cleared after last pixel");

endmodule

`default_nettype wire

[design/opc_out_buf.sv]
// Two-entry result buffer between the cell chain and the result channel.
// Depends on opc_pkg and opc_if; room_o paces the whole chain.
`default_nettype none

module opc_out_buf (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  opc_pkg::opc_res_t   res_i,
  output logic                room_o,
  opc_out_if.source           out_o
);
  import opc_pkg::*;

  opc_res_t   ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop    = out_o.valid && out_o.ready;
  assign room_o = cnt_q != 2'd2;

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= res_i;
    end
  end

  assign out_o.valid           = cnt_q != 2'd0;
  assign out_o.predicted_class = ent_q[rd_ptr_q].predicted_class;
  assign out_o.is_mismatch     = ent_q[rd_ptr_q].is_mismatch;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'd2)
    else $error("result pushed into full buffer");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
    else $error("full buffer changed without a pop");

endmodule

`default_nettype wire

[design/one_vs_rest_linear_classifier.sv]
// Top level of the one-vs-rest linear classifier: input register, cell chain
// and result buffer. Depends on opc_pkg, opc_if, opc_cell and opc_out_buf.
//
// Usage:
//   in_i carries one beat per item: a weight write (action 0) or one pixel
//   (action 1). Pixels arrive in row order; last_pixel closes an image and
//   carries its true_label. out_o carries one beat per image: the class with
//   the highest score (lowest index on ties) and the mismatch flag.
//   Throughput is one item per cycle while the result buffer has room. Every
//   item walks a chain of one cell per class, through registers a_q, b_q,
//   c_q and d_q in each cell, after the input register tok_in_q.
//   Weight writes travel the same chain, so they take effect in stream order.
//   Reset clears scores, pixel positions and the chain; weights are not
//   cleared and must be loaded before an image reads them.
//   A two-entry result buffer sits before out_o; the chain and in_i stall
//   only while both entries are occupied, so in_i.ready does not depend on
//   out_o.ready in the same cycle.
`default_nettype none

module one_vs_rest_linear_classifier (
  input  wire        clk_i,
  input  wire        rst_ni,
  opc_in_if.sink     in_i,
  opc_out_if.source  out_o
);
  import opc_pkg::*;

  opc_tok_t tok_in_q;
  opc_tok_t chain [CLASS_COUNT + 1];
  opc_res_t res;
  opc_tok_t tail;
  logic     adv, room, push;

  assign adv        = room;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_in_q <= '0;
    end else if (adv) begin
      tok_in_q.valid        <= in_i.valid;
      tok_in_q.action       <= action_e'(in_i.action);
      tok_in_q.class_index  <= in_i.class_index;
      tok_in_q.weight_index <= in_i.weight_index;
      tok_in_q.weight_value <= in_i.weight_value;
      tok_in_q.pixel_value  <= in_i.pixel_value;
      tok_in_q.last_pixel   <= in_i.last_pixel;
      tok_in_q.true_label   <= in_i.true_label;
      tok_in_q.best_score   <= '0;
      tok_in_q.best_class   <= '0;
    end
  end

  assign chain[0] = tok_in_q;

  for (genvar c = 0; c < CLASS_COUNT; c++) begin : g_cell
    opc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .cell_id_i (CLASS_W'(c)),
      .tok_i     (chain[c]),
      .tok_o     (chain[c + 1])
    );
  end

  assign tail = chain[CLASS_COUNT];
  assign push = adv && tail.valid && tail.action == ACT_PIXEL && tail.last_pixel;
  assign res.predicted_class = tail.best_class;
  assign res.is_mismatch     = tail.best_class != tail.true_label;

  opc_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res_i  (res),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
